// File: rtl/priority_edf_task_selector_macros.svh
// Assertion macros shared by the priority task selector RTL.
// Standalone header; no dependencies.
`ifndef PRIORITY_EDF_TASK_SELECTOR_MACROS_SVH
`define PRIORITY_EDF_TASK_SELECTOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PETS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PETS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pets_pkg.sv
// Types and constants for the priority task selector with deadline tie break.
// No dependencies; used by priority_edf_task_selector.
`timescale 1ns / 1ps
`default_nettype none

package pets_pkg;

  localparam int unsigned SlotCountDef = 16;
  localparam int unsigned PrioBitsDef  = 8;
  localparam logic [31:0] DeadlineNone = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    MODE_CREATE    = 3'd0,
    MODE_DELETE    = 3'd1,
    MODE_ACTIVATE  = 3'd2,
    MODE_COMPLETE  = 3'd3,
    MODE_PICK      = 3'd4,
    MODE_SET_DL    = 3'd5,
    MODE_SET_BOOST = 3'd6
  } mode_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_BAD_ID = 2'd1,
    STS_FULL   = 2'd2,
    STS_NONE   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_CREATED   = 2'd0,
    PH_READY     = 2'd1,
    PH_COMPLETED = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_SCAN = 2'd2
  } state_e;

  typedef struct packed {
    mode_e       mode;
    logic [4:0]  task_id;
    logic [7:0]  priority_req;
    logic [31:0] deadline;
  } cmd_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  result_id;
    logic        found;
    logic [7:0]  chosen_priority;
    logic [31:0] chosen_deadline;
    logic [31:0] decisions_made;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/priority_edf_task_selector.sv
// Priority task selector: task table, single-slot operations and a sequential
// pick-next / create scan. Depends on pets_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_edf_task_selector_macros.svh"

// Delete, activate, complete, set deadline, set boost and an invalid mode run through the
// EXEC state and strobe done_o from a register; create scans one slot per cycle up to the
// first free slot and pick next always scans every slot, bounded by the one slot read port
// and the shared priority/deadline comparator. busy drops in the strobe cycle, so a new
// transaction can be accepted while done_o is high; the receiver cannot stall results.
// Reset clears the whole table and the decision counter at once.
module priority_edf_task_selector
  import pets_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SlotCountDef,
  parameter int unsigned PRIO_BITS  = PrioBitsDef
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  start,
  input  cmd_t cmd_i,
  output logic busy,
  output logic done_o,
  output res_t result_o
);

  localparam int unsigned IdxW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned PrioW = (PRIO_BITS < 8) ? PRIO_BITS : 8;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  typedef struct packed {
    logic             used;
    phase_e           phase;
    logic [PrioW-1:0] base;
    logic [PrioW-1:0] boost;
    logic [31:0]      deadline;
  } slot_t;

  slot_t            slots_q [SLOT_COUNT];
  state_e           state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic             id_ok_q, id_ok_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             have_q, have_d;
  logic [PrioW-1:0] bp_q, bp_d;
  logic [31:0]      bd_q, bd_d;
  logic [IdxW-1:0]  best_q, best_d;
  logic [31:0]      cnt_q, cnt_d;
  res_t             res_q, res_d;
  logic             done_q, done_d;

  slot_t            rd;
  slot_t            wd;
  logic             slot_we;
  logic [PrioW-1:0] prio;
  logic [PrioW-1:0] eff;
  logic             cand;
  logic             better;
  logic             last;
  logic             accept;

  assign accept = start && (state_q == S_IDLE);
  assign rd     = slots_q[idx_q];
  assign prio   = cmd_q.priority_req[PrioW-1:0];
  assign last   = (idx_q == LastIdx);
  assign eff    = (rd.boost > rd.base) ? rd.boost : rd.base;
  assign cand   = rd.used && (rd.phase == PH_READY);
  // The single shared comparator: higher priority wins, then strictly earlier deadline.
  assign better = cand && ((eff > bp_q) || ((eff == bp_q) && (rd.deadline < bd_q)));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (cmd_i.mode == MODE_CREATE || cmd_i.mode == MODE_PICK) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_EXEC: state_d = S_IDLE;
      S_SCAN: begin
        if (last || (cmd_q.mode == MODE_CREATE && !rd.used)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    cmd_d   = cmd_q;
    id_ok_d = id_ok_q;
    idx_d   = idx_q;
    have_d  = have_q;
    bp_d    = bp_q;
    bd_d    = bd_q;
    best_d  = best_q;
    cnt_d   = cnt_q;
    slot_we = 1'b0;
    wd      = rd;
    done_d  = 1'b0;
    res_d   = '0;
    res_d.status         = STS_OK;
    res_d.decisions_made = cnt_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_i;
          id_ok_d = (32'(cmd_i.task_id) < SLOT_COUNT);
          have_d  = 1'b0;
          bp_d    = '0;
          bd_d    = DeadlineNone;
          best_d  = '0;
          if (cmd_i.mode == MODE_CREATE || cmd_i.mode == MODE_PICK) begin
            idx_d = '0;
          end else begin
            idx_d = cmd_i.task_id[IdxW-1:0];
          end
        end
      end

      S_EXEC: begin
        done_d = 1'b1;
        if (!id_ok_q) begin
          res_d.status = STS_BAD_ID;
        end else begin
          case (cmd_q.mode)
            MODE_DELETE: begin
              slot_we = 1'b1;
              wd      = '0;
            end
            MODE_ACTIVATE: begin
              if (!rd.used) begin
                res_d.status = STS_NONE;
              end else if (rd.phase == PH_CREATED || rd.phase == PH_COMPLETED) begin
                slot_we  = 1'b1;
                wd.phase = PH_READY;
              end
            end
            MODE_COMPLETE: begin
              slot_we  = 1'b1;
              wd.phase = PH_COMPLETED;
            end
            MODE_SET_DL: begin
              slot_we     = 1'b1;
              wd.deadline = cmd_q.deadline;
            end
            MODE_SET_BOOST: begin
              slot_we  = 1'b1;
              wd.boost = prio;
            end
            default: res_d.status = STS_BAD_ID;
          endcase
        end
      end

      S_SCAN: begin
        if (cmd_q.mode == MODE_CREATE) begin
          if (!rd.used) begin
            slot_we           = 1'b1;
            wd.used           = 1'b1;
            wd.phase          = PH_CREATED;
            wd.base           = prio;
            wd.boost          = prio;
            wd.deadline       = cmd_q.deadline;
            done_d            = 1'b1;
            res_d.result_id   = 4'(idx_q);
          end else if (last) begin
            done_d       = 1'b1;
            res_d.status = STS_FULL;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end else begin
          if (better) begin
            have_d = 1'b1;
            bp_d   = eff;
            bd_d   = rd.deadline;
            best_d = idx_q;
          end
          if (last) begin
            done_d               = 1'b1;
            cnt_d                = cnt_q + 32'd1;
            res_d.decisions_made = cnt_q + 32'd1;
            if (have_d) begin
              res_d.found           = 1'b1;
              res_d.result_id       = 4'(best_d);
              res_d.chosen_priority = 8'(bp_d);
              res_d.chosen_deadline = bd_d;
            end else begin
              res_d.status = STS_NONE;
            end
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end

      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      id_ok_q <= 1'b0;
      idx_q   <= '0;
      have_q  <= 1'b0;
      bp_q    <= '0;
      bd_q    <= DeadlineNone;
      best_q  <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      for (int unsigned i = 0; i < SLOT_COUNT; i++) begin
        slots_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      id_ok_q <= id_ok_d;
      idx_q   <= idx_d;
      have_q  <= have_d;
      bp_q    <= bp_d;
      bd_q    <= bd_d;
      best_q  <= best_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      if (slot_we) begin
        slots_q[idx_q] <= wd;
      end
    end
  end

  // Command and result payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  `PETS_ASSERT_IMP(a_done_follows_work, clk_i, rst_ni, done_q, $past(busy),
    "result strobe without a preceding working cycle")
  `PETS_ASSERT_NXT(a_accept_goes_busy, clk_i, rst_ni, start && !busy, busy,
    "accepted transaction did not start work")
  `PETS_ASSERT_IMP(a_found_is_ok, clk_i, rst_ni, done_q && res_q.found,
    res_q.status == STS_OK, "pick reported a task with a failing status")
  `PETS_ASSERT_IMP(a_scan_in_range, clk_i, rst_ni, state_q == S_SCAN,
    32'(idx_q) < SLOT_COUNT, "scan index ran past the table")
  `PETS_ASSERT_IMP(a_counter_on_pick, clk_i, rst_ni, !$stable(cnt_q),
    done_q && (cmd_q.mode == MODE_PICK), "decision counter moved without a pick")

endmodule

`default_nettype wire
